[rtl/wpc_pkg.sv]
// wpc_pkg: shared types, constants and the arctangent table for the
// waypoint pursuit controller; no dependencies
package wpc_pkg;

	localparam int MAX_WAYPOINTS_DEF = 256;
	localparam int CORDIC_STEPS_DEF  = 16;
	localparam int CFG_W             = 31;
	localparam int XW                = 36;	// cordic x/y width
	localparam int ZW                = 34;	// cordic angle width, signed Q5.29
	localparam int EW                = 35;	// heading error width
	localparam int DW                = 37;	// distance width

	localparam logic signed [ZW-1:0] PI_Q29     = 34'sd1686629713;
	localparam logic signed [EW-1:0] PI_Q29_E   = 35'sd1686629713;
	localparam logic signed [EW-1:0] TWO_PI_Q29 = 35'sd3373259426;
	localparam logic [31:0]          INV_GAIN   = 32'h9B74_EDA8;

	localparam logic [15:0] GAIN_LIN_RST  = 16'd256;
	localparam logic [15:0] GAIN_ANG_RST  = 16'd128;
	localparam logic [30:0] SPEED_LIM_RST = 31'd131072;
	localparam logic [14:0] TURN_LIM_RST  = 15'd4096;
	localparam logic [30:0] ARRIVE_RST    = 31'd6554;

	localparam logic OP_WAYPOINT = 1'b0;
	localparam logic OP_POSE     = 1'b1;

	typedef enum logic [2:0] {
		CFG_GAIN_LINEAR  = 3'd0,
		CFG_GAIN_ANGULAR = 3'd1,
		CFG_SPEED_LIMIT  = 3'd2,
		CFG_TURN_LIMIT   = 3'd3,
		CFG_ARRIVE       = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic               operation;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic               last_waypoint;
	} in_item_t;

	typedef struct packed {
		logic [30:0]        fwd_speed;
		logic signed [15:0] turn_rate;
		logic               waypoint_reached;
		logic               path_done;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DONE,
		ST_INIT,
		ST_ITER,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic cap;
		logic wr;
		logic rd;
		logic init;
		logic iter;
		logic mul1;
		logic mul2;
		logic mul3;
		logic fin_out;
		logic done_out;
	} cmd_t;

	typedef struct packed {
		logic op_pose;
		logic loaded;
		logic finished;
		logic step_last;
		logic out_free;
	} sts_t;

	function automatic logic signed [ZW-1:0] atan_q29(input logic [4:0] i);
		logic signed [ZW-1:0] r;
		r = '0;
		case (i)
			5'd0: r = 34'sd421657428;
			5'd1: r = 34'sd248918915;
			5'd2: r = 34'sd131521918;
			5'd3: r = 34'sd66762579;
			5'd4: r = 34'sd33510843;
			5'd5: r = 34'sd16771758;
			5'd6: r = 34'sd8387925;
			5'd7: r = 34'sd4194219;
			5'd8: r = 34'sd2097141;
			5'd9: r = 34'sd1048575;
			5'd30, 5'd31: r = '0;
			default: r = 34'sd1 <<< (5'd29 - i);
		endcase
		return r;
	endfunction

endpackage

[rtl/waypoint_pursuit_controller_top.sv]
// waypoint_pursuit_controller_top: proportional waypoint follower
// depends on wpc_pkg, wpc_ctrl, wpc_dp
//
//  channel  | signals                         | beat
//  in       | in_valid, in_ready, in_data     | waypoint or pose sample
//  out      | out_valid, out_ready, out_data  | velocity command
//  cfg      | cfg_we, cfg_index, cfg_data     | register write, no wait
//
// one item at a time: a waypoint or a pose before load passes idle and
// decode, a pose on a finished path also the done state, a full pose
// also init, the iterative cordic loop, mul1, mul2, mul3 and the final state
// the output register holds a finished command until taken; a stalled
// output stalls only the final and done states, the next beat waits for idle
// reset sets the config to its defaults and clears the path counters and the output valid
module waypoint_pursuit_controller_top #(
	parameter int MAX_WAYPOINTS = wpc_pkg::MAX_WAYPOINTS_DEF,
	parameter int CORDIC_STEPS  = wpc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  wpc_pkg::in_item_t            in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output wpc_pkg::out_item_t           out_data,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [wpc_pkg::CFG_W-1:0]    cfg_data
);

	wpc_pkg::cmd_t cmd;
	wpc_pkg::sts_t sts;

	wpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wpc_dp #(
		.MAX_WAYPOINTS (MAX_WAYPOINTS),
		.CORDIC_STEPS  (CORDIC_STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

[rtl/wpc_ctrl.sv]
// wpc_ctrl: sequencing state machine for the waypoint pursuit controller
// depends on wpc_pkg
module wpc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wpc_pkg::sts_t sts,
	output wpc_pkg::cmd_t cmd
);

	wpc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wpc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wpc_pkg::ST_IDLE: begin
				if (in_valid) state_d = wpc_pkg::ST_DECODE;
			end
			wpc_pkg::ST_DECODE: begin
				if (!sts.op_pose || !sts.loaded) state_d = wpc_pkg::ST_IDLE;
				else if (sts.finished) state_d = wpc_pkg::ST_DONE;
				else state_d = wpc_pkg::ST_INIT;
			end
			wpc_pkg::ST_DONE: begin
				if (sts.out_free) state_d = wpc_pkg::ST_IDLE;
			end
			wpc_pkg::ST_INIT: state_d = wpc_pkg::ST_ITER;
			wpc_pkg::ST_ITER: begin
				if (sts.step_last) state_d = wpc_pkg::ST_MUL1;
			end
			wpc_pkg::ST_MUL1: state_d = wpc_pkg::ST_MUL2;
			wpc_pkg::ST_MUL2: state_d = wpc_pkg::ST_MUL3;
			wpc_pkg::ST_MUL3: state_d = wpc_pkg::ST_FIN;
			wpc_pkg::ST_FIN: begin
				if (sts.out_free) state_d = wpc_pkg::ST_IDLE;
			end
			default: state_d = wpc_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			wpc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.cap  = in_valid;
			end
			wpc_pkg::ST_DECODE: begin
				cmd.wr = !sts.op_pose;
				cmd.rd = sts.op_pose;
			end
			wpc_pkg::ST_DONE: cmd.done_out = sts.out_free;
			wpc_pkg::ST_INIT: cmd.init = 1'b1;
			wpc_pkg::ST_ITER: cmd.iter = 1'b1;
			wpc_pkg::ST_MUL1: cmd.mul1 = 1'b1;
			wpc_pkg::ST_MUL2: cmd.mul2 = 1'b1;
			wpc_pkg::ST_MUL3: cmd.mul3 = 1'b1;
			wpc_pkg::ST_FIN: cmd.fin_out = sts.out_free;
			default: ;
		endcase
	end

endmodule

[rtl/wpc_dp.sv]
// wpc_dp: waypoint store, config registers, iterative cordic, gain
// multipliers and output register; depends on wpc_pkg
module wpc_dp #(
	parameter int MAX_WAYPOINTS = wpc_pkg::MAX_WAYPOINTS_DEF,
	parameter int CORDIC_STEPS  = wpc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wpc_pkg::in_item_t   in_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [wpc_pkg::CFG_W-1:0] cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output wpc_pkg::out_item_t  out_data,
	input  wpc_pkg::cmd_t       cmd,
	output wpc_pkg::sts_t       sts
);

	localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);
	localparam int SW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// configuration
	logic [15:0] gain_lin_q, gain_ang_q;
	logic [30:0] speed_lim_q, arrive_q;
	logic [14:0] turn_lim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_lin_q  <= wpc_pkg::GAIN_LIN_RST;
			gain_ang_q  <= wpc_pkg::GAIN_ANG_RST;
			speed_lim_q <= wpc_pkg::SPEED_LIM_RST;
			turn_lim_q  <= wpc_pkg::TURN_LIM_RST;
			arrive_q    <= wpc_pkg::ARRIVE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wpc_pkg::CFG_GAIN_LINEAR:  gain_lin_q  <= cfg_data[15:0];
				wpc_pkg::CFG_GAIN_ANGULAR: gain_ang_q  <= cfg_data[15:0];
				wpc_pkg::CFG_SPEED_LIMIT:  speed_lim_q <= cfg_data[30:0];
				wpc_pkg::CFG_TURN_LIMIT:   turn_lim_q  <= cfg_data[14:0];
				wpc_pkg::CFG_ARRIVE:       arrive_q    <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// captured input beat
	wpc_pkg::in_item_t in_q;
	always_ff @(posedge clk) begin
		if (cmd.cap) in_q <= in_data;
	end

	// path state
	logic [CW-1:0] count_q, target_q;
	logic          loaded_q;
	logic          reached_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			target_q <= '0;
			loaded_q <= 1'b0;
		end else begin
			if (cmd.wr && !loaded_q) begin
				if (count_q < CW'(MAX_WAYPOINTS)) count_q <= count_q + 1'b1;
				if (in_q.last_waypoint) begin
					loaded_q <= 1'b1;
					target_q <= '0;
				end
			end
			if (cmd.fin_out && reached_q) target_q <= target_q + 1'b1;
		end
	end

	// waypoint memory
	logic [31:0] mem_x [MAX_WAYPOINTS];
	logic [31:0] mem_y [MAX_WAYPOINTS];
	logic [31:0] rd_x_q, rd_y_q;

	always_ff @(posedge clk) begin
		if (cmd.wr && !loaded_q && count_q < CW'(MAX_WAYPOINTS)) begin
			mem_x[count_q[AW-1:0]] <= in_q.pos_x;
			mem_y[count_q[AW-1:0]] <= in_q.pos_y;
		end
		if (cmd.rd) begin
			rd_x_q <= mem_x[target_q[AW-1:0]];
			rd_y_q <= mem_y[target_q[AW-1:0]];
		end
	end

	// cordic vectoring
	logic signed [wpc_pkg::XW-1:0] x_q, y_q, xs, ys;
	logic signed [wpc_pkg::ZW-1:0] z_q;
	logic [SW-1:0]                 step_q;
	logic signed [32:0]            dx, dy;
	logic signed [wpc_pkg::XW-1:0] dx_e, dy_e;

	assign dx   = {rd_x_q[31], rd_x_q} - {in_q.pos_x[31], in_q.pos_x};
	assign dy   = {rd_y_q[31], rd_y_q} - {in_q.pos_y[31], in_q.pos_y};
	assign dx_e = wpc_pkg::XW'(dx);
	assign dy_e = wpc_pkg::XW'(dy);
	assign xs   = x_q >>> step_q;
	assign ys   = y_q >>> step_q;

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			step_q <= '0;
			if (dx < 0) begin
				x_q <= -dx_e;
				y_q <= -dy_e;
				z_q <= (dy >= 0) ? wpc_pkg::PI_Q29 : -wpc_pkg::PI_Q29;
			end else begin
				x_q <= dx_e;
				y_q <= dy_e;
				z_q <= '0;
			end
		end else if (cmd.iter) begin
			step_q <= step_q + 1'b1;
			if (y_q >= 0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + wpc_pkg::atan_q29(5'(step_q));
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - wpc_pkg::atan_q29(5'(step_q));
			end
		end
	end

	// gain and scaling
	logic [63:0]                   prod_s1;
	logic [3:0]                    hi_s1;
	logic signed [wpc_pkg::EW-1:0] err_raw, err_q;
	logic [63:0]                   rnd;
	logic [wpc_pkg::DW-1:0]        dist_q;
	logic signed [51:0]            angp_q;
	logic [52:0]                   linp_q;
	logic signed [16:0]            ga;

	assign err_raw = wpc_pkg::EW'(z_q) - {{3{in_q.heading[15]}}, in_q.heading, 16'b0};
	assign rnd     = prod_s1 + 64'h8000_0000;
	assign ga      = {1'b0, gain_ang_q};

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			prod_s1 <= 64'(x_q[31:0]) * 64'(wpc_pkg::INV_GAIN);
			hi_s1   <= x_q[35:32];
			// wrap heading error once into (-pi, pi]
			if (err_raw > wpc_pkg::PI_Q29_E) err_q <= err_raw - wpc_pkg::TWO_PI_Q29;
			else if (err_raw <= -wpc_pkg::PI_Q29_E) err_q <= err_raw + wpc_pkg::TWO_PI_Q29;
			else err_q <= err_raw;
		end
		if (cmd.mul2) begin
			dist_q <= wpc_pkg::DW'(36'(hi_s1) * 36'(wpc_pkg::INV_GAIN))
				+ wpc_pkg::DW'(rnd[63:32]);
			angp_q <= 52'(ga) * 52'(err_q);
		end
		if (cmd.mul3) begin
			linp_q    <= 53'(gain_lin_q) * 53'(dist_q);
			reached_q <= dist_q < wpc_pkg::DW'(arrive_q);
		end
	end

	// final clamps
	logic [44:0]        lin_full;
	logic [30:0]        lin_c;
	logic signed [51:0] ang_full, tl;
	logic signed [15:0] ang_c;

	assign lin_full = linp_q[52:8];
	assign lin_c    = (lin_full > 45'(speed_lim_q)) ? speed_lim_q : lin_full[30:0];
	assign ang_full = (angp_q + 52'sd8388608) >>> 24;
	assign tl       = 52'(signed'({1'b0, turn_lim_q}));

	always_comb begin
		if (ang_full > tl) ang_c = tl[15:0];
		else if (ang_full < -tl) ang_c = 16'(-tl);
		else ang_c = ang_full[15:0];
	end

	// output register
	logic                 out_valid_q;
	wpc_pkg::out_item_t   out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin_out || cmd.done_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_out) begin
			out_q.fwd_speed        <= lin_c;
			out_q.turn_rate        <= ang_c;
			out_q.waypoint_reached <= reached_q;
			out_q.path_done        <= 1'b0;
		end else if (cmd.done_out) begin
			out_q <= '{fwd_speed: '0, turn_rate: '0,
				waypoint_reached: 1'b0, path_done: 1'b1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign sts.op_pose   = (in_q.operation == wpc_pkg::OP_POSE);
	assign sts.loaded    = loaded_q;
	assign sts.finished  = (target_q >= count_q);
	assign sts.step_last = (step_q == SW'(CORDIC_STEPS - 1));
	assign sts.out_free  = !out_valid_q || out_ready;

endmodule

[rtl/wpc_checker.sv]
// wpc_checker: port-level assertions for the waypoint pursuit controller,
// bound to the top level; depends on wpc_pkg
module wpc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input wpc_pkg::out_item_t out_data
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	// a stop command carries zero speeds
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.path_done |->
			out_data.fwd_speed == '0 && out_data.turn_rate == '0)
		else $error("done command with nonzero speed");

	a_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.path_done && out_data.waypoint_reached))
		else $error("done and reached both set");

	// one beat at a time
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

endmodule

bind waypoint_pursuit_controller_top wpc_checker u_wpc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
